// File: hw/rtl/olief_pkg.sv
// olief_pkg: shared types and constants of the ordered list block
// request and status codes, cell command, search result and fsm state types
// no dependencies
package olief_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int REQ_W          = 2;
    localparam int POS_W          = 5;
    localparam int DATA_W         = 32;
    localparam int STATUS_W       = 3;
    localparam int FIDX_W         = 4;
    localparam int COUNT_W        = 5;
    localparam int GROUP_WIDTH    = 16;
    localparam int GROUP_BITS     = 4;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_SEARCH
    } fsm_state_t;

    typedef struct packed {
        logic insert;
        logic erase;
        logic compare;
    } cell_cmd_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [FIDX_W-1:0] idx;
    } scan_res_t;

endpackage

// File: hw/rtl/olief_cell.sv
// olief_cell: one list slot, holds an entry and its match flag
// shifts from its neighbors on insert and erase, compares on find
// depends on olief_pkg
module olief_cell #(
    parameter int INDEX = 0,
    parameter int PW    = 5
) (
    input  logic                          clk,
    input  olief_pkg::cell_cmd_t          cmd,
    input  logic [PW-1:0]                 pos,
    input  logic [PW-1:0]                 cnt,
    input  logic [olief_pkg::DATA_W-1:0]  key,
    input  logic [olief_pkg::DATA_W-1:0]  left_data,
    input  logic [olief_pkg::DATA_W-1:0]  right_data,
    output logic [olief_pkg::DATA_W-1:0]  data,
    output logic                          match
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    logic [olief_pkg::DATA_W-1:0] entry_reg;
    logic [olief_pkg::DATA_W-1:0] entry_next;
    logic                         match_reg;
    logic                         match_next;

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        if (cmd.insert)
        begin
            if (IDX == pos)
                entry_next = key;
            else if (IDX > pos && IDX <= cnt)
                entry_next = left_data;
        end
        else if (cmd.erase)
        begin
            if (IDX >= pos)
                entry_next = right_data;
        end
        if (cmd.compare)
            match_next = (entry_reg == key) && (IDX < cnt);
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign data  = entry_reg;
    assign match = match_reg;

endmodule

// File: hw/rtl/olief_scan.sv
// olief_scan: first-match search over the cell match flags
// walks the flags one group of sixteen per cycle, stops at the first hit
// depends on olief_pkg
module olief_scan #(
    parameter int LIST_DEPTH = olief_pkg::LIST_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [LIST_DEPTH-1:0]  match,
    output olief_pkg::scan_res_t   res
);

    localparam int GW   = olief_pkg::GROUP_WIDTH;
    localparam int GBW  = olief_pkg::GROUP_BITS;
    localparam int NG   = (LIST_DEPTH + GW - 1) / GW;
    localparam int GCW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW = NG * GW;

    logic [PADW-1:0] padded;
    logic [GW-1:0]   grp_bits;
    logic [GBW-1:0]  enc;
    logic            any_hit;
    logic            last;

    logic            active_reg;
    logic            active_next;
    logic [GCW-1:0]  grp_reg;
    logic [GCW-1:0]  grp_next;
    logic            done_reg;
    logic            done_next;
    logic            hit_reg;
    logic            hit_next;
    logic [GBW-1:0]  idx_reg;
    logic [GBW-1:0]  idx_next;

    assign padded   = PADW'(match);
    assign grp_bits = padded[grp_reg*GW +: GW];
    assign any_hit  = |grp_bits;
    assign last     = (grp_reg == GCW'(NG - 1));

    always_comb
    begin
        enc = '0;
        for (int i = GW - 1; i >= 0; i--)
        begin
            if (grp_bits[i])
                enc = GBW'(i);
        end
    end

    always_comb
    begin
        active_next = active_reg;
        grp_next    = grp_reg;
        done_next   = 1'b0;
        hit_next    = hit_reg;
        idx_next    = idx_reg;
        if (go)
        begin
            active_next = 1'b1;
            grp_next    = '0;
        end
        else if (active_reg)
        begin
            if (any_hit || last)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
                hit_next    = any_hit;
                idx_next    = any_hit ? enc : '0;
            end
            else
            begin
                grp_next = grp_reg + GCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            grp_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            grp_reg    <= grp_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        idx_reg <= idx_next;
    end

    assign res.done = done_reg;
    assign res.hit  = hit_reg;
    assign res.idx  = idx_reg;

endmodule

// File: hw/rtl/ordered_list_insert_erase_find.sv
// ordered_list_insert_erase_find: top level of the ordered list block
// chain of olief_cell slots, olief_scan first-match search, request fsm
// depends on olief_pkg, olief_cell, olief_scan
//
// usage
//   an item (req_type, position, value) is taken at a rising edge with start
//   high and busy low. each item gives one result (status, found_index,
//   count) shown for exactly one cycle while done is high.
//   insert and erase: on success the slots from position on shift in the
//   accept cycle; done follows in the next cycle; busy stays low, so one
//   such item is taken every cycle. find: the slots compare in the accept
//   cycle, then the search walks the match flags sixteen slots per cycle
//   and stops at the first hit; busy is high from accept up to and
//   including the cycle in which done is shown.
//   unused request code: status ok, no change, done in the next cycle.
//   found_index and count carry the low bits of the index and the count.
//   reset empties the list; entry contents are left undefined.
//   the receiver cannot stall: done is a strobe with no back pressure.
module ordered_list_insert_erase_find #(
    parameter int LIST_DEPTH = olief_pkg::LIST_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [olief_pkg::REQ_W-1:0]     req_type,
    input  logic [olief_pkg::POS_W-1:0]     position,
    input  logic signed [olief_pkg::DATA_W-1:0] value,
    output logic                            done,
    output logic [olief_pkg::STATUS_W-1:0]  status,
    output logic [olief_pkg::FIDX_W-1:0]    found_index,
    output logic [olief_pkg::COUNT_W-1:0]   count
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int PW = (CW > olief_pkg::POS_W) ? CW : olief_pkg::POS_W;

    olief_pkg::fsm_state_t          state_reg;
    olief_pkg::fsm_state_t          state_next;
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_next;
    logic                           done_reg;
    logic                           done_next;
    olief_pkg::status_t             status_reg;
    olief_pkg::status_t             status_next;

    olief_pkg::cell_cmd_t           cmd;
    olief_pkg::scan_res_t           scan_res;
    logic                           accept;
    logic                           go;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [olief_pkg::DATA_W-1:0]   key;
    logic [olief_pkg::DATA_W-1:0]   entry_q [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]          match_vec;

    assign busy    = (state_reg == olief_pkg::FSM_SEARCH);
    assign accept  = start && !busy;
    assign pos_ext = PW'(position);
    assign cnt_ext = PW'(cnt_reg);
    assign key     = value;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        cmd         = '0;
        go          = 1'b0;
        unique case (state_reg)
            olief_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    priority if (req_type == olief_pkg::REQ_INSERT)
                    begin
                        done_next = 1'b1;
                        if (cnt_reg == CW'(LIST_DEPTH))
                            status_next = olief_pkg::ST_FULL;
                        else if (pos_ext > cnt_ext)
                            status_next = olief_pkg::ST_BADPOS;
                        else
                        begin
                            status_next = olief_pkg::ST_OK;
                            cmd.insert  = 1'b1;
                            cnt_next    = cnt_reg + CW'(1);
                        end
                    end
                    else if (req_type == olief_pkg::REQ_ERASE)
                    begin
                        done_next = 1'b1;
                        if (cnt_reg == '0)
                            status_next = olief_pkg::ST_EMPTY;
                        else if (pos_ext >= cnt_ext)
                            status_next = olief_pkg::ST_BADPOS;
                        else
                        begin
                            status_next = olief_pkg::ST_OK;
                            cmd.erase   = 1'b1;
                            cnt_next    = cnt_reg - CW'(1);
                        end
                    end
                    else if (req_type == olief_pkg::REQ_FIND)
                    begin
                        cmd.compare = 1'b1;
                        go          = 1'b1;
                        state_next  = olief_pkg::FSM_SEARCH;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        status_next = olief_pkg::ST_OK;
                    end
                end
            end
            olief_pkg::FSM_SEARCH:
            begin
                if (scan_res.done)
                    state_next = olief_pkg::FSM_IDLE;
            end
            default:
            begin
                state_next = olief_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= olief_pkg::FSM_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= olief_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [olief_pkg::DATA_W-1:0] left_data;
        logic [olief_pkg::DATA_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = key;
        end
        else
        begin : g_left
            assign left_data = entry_q[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_data = key;
        end
        else
        begin : g_right
            assign right_data = entry_q[i+1];
        end

        olief_cell #(
            .INDEX (i),
            .PW    (PW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_ext),
            .cnt        (cnt_ext),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (entry_q[i]),
            .match      (match_vec[i])
        );
    end

    olief_scan #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .match (match_vec),
        .res   (scan_res)
    );

    assign done        = done_reg || scan_res.done;
    assign status      = scan_res.done
                         ? (scan_res.hit ? olief_pkg::ST_OK : olief_pkg::ST_NOTFOUND)
                         : status_reg;
    assign found_index = scan_res.done ? scan_res.idx : '0;
    assign count       = olief_pkg::COUNT_W'(cnt_reg);

    // search results only come back while a find is in progress
    a_scan_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> state_reg == olief_pkg::FSM_SEARCH)
        else $error("search result outside a find");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(LIST_DEPTH))
        else $error("entry count above list depth");

    // a successful insert grows the list by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("insert did not grow the count");

    // an op result and a search result never collide
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && scan_res.done))
        else $error("two results in one cycle");

endmodule

// File: tb/olief_list_checker.sv
`timescale 1ns / 100ps
// olief_list_checker: scoreboard for the ordered list block
// keeps its own copy of the list, predicts every result and compares in order
// depends on olief_pkg
module olief_list_checker #(
    parameter int LIST_DEPTH = olief_pkg::LIST_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [olief_pkg::REQ_W-1:0]         req_type,
    input  logic [olief_pkg::POS_W-1:0]         position,
    input  logic signed [olief_pkg::DATA_W-1:0] value,
    input  logic                                done,
    input  logic [olief_pkg::STATUS_W-1:0]      status,
    input  logic [olief_pkg::FIDX_W-1:0]        found_index,
    input  logic [olief_pkg::COUNT_W-1:0]       count,
    output int                                  fail_count,
    output int                                  pending,
    output int                                  list_len
);

    typedef struct packed {
        olief_pkg::status_t            st;
        logic [olief_pkg::FIDX_W-1:0]  idx;
        logic [olief_pkg::COUNT_W-1:0] cnt;
    } list_result_t;

    logic signed [olief_pkg::DATA_W-1:0] cells [LIST_DEPTH];
    int                                  cell_count;
    list_result_t                        results_due [$];

    assign list_len = cell_count;

    initial
    begin
        cell_count = 0;
        fail_count = 0;
        pending    = 0;
    end

    // applies one request to the list copy and returns its result
    function automatic list_result_t list_request(
        input logic [olief_pkg::REQ_W-1:0]         kind,
        input logic [olief_pkg::POS_W-1:0]         pos,
        input logic signed [olief_pkg::DATA_W-1:0] val
    );
        list_result_t r;
        int           i;
        r.st  = olief_pkg::ST_OK;
        r.idx = '0;
        case (kind)
            olief_pkg::REQ_INSERT:
            begin
                if (cell_count >= LIST_DEPTH)
                    r.st = olief_pkg::ST_FULL;
                else if (int'(pos) > cell_count)
                    r.st = olief_pkg::ST_BADPOS;
                else
                begin
                    for (i = cell_count; i > int'(pos); i--)
                        cells[i] = cells[i-1];
                    cells[pos] = val;
                    cell_count++;
                end
            end
            olief_pkg::REQ_ERASE:
            begin
                if (cell_count == 0)
                    r.st = olief_pkg::ST_EMPTY;
                else if (int'(pos) >= cell_count)
                    r.st = olief_pkg::ST_BADPOS;
                else
                begin
                    for (i = int'(pos); i + 1 < cell_count; i++)
                        cells[i] = cells[i+1];
                    cell_count--;
                end
            end
            olief_pkg::REQ_FIND:
            begin
                r.st = olief_pkg::ST_NOTFOUND;
                for (i = 0; i < cell_count; i++)
                begin
                    if (r.st == olief_pkg::ST_NOTFOUND && cells[i] == val)
                    begin
                        r.st  = olief_pkg::ST_OK;
                        r.idx = i[olief_pkg::FIDX_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        r.cnt = cell_count[olief_pkg::COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (results_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: result with none due: status %0d idx %0d count %0d",
                                 $realtime, status, found_index, count);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (status !== want.st || found_index !== want.idx ||
                        count !== want.cnt)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch: expected status %0d idx %0d count %0d,",
                                      " got status %0d idx %0d count %0d"},
                                     $realtime, want.st, want.idx, want.cnt,
                                     status, found_index, count);
                        fail_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                results_due.push_back(list_request(req_type, position, value));
            pending = results_due.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: stimulus and verdict for ordered_list_insert_erase_find
// directed corner items, then bursts of random requests; checking in olief_list_checker
// depends on olief_pkg, olief_list_checker and the block's rtl
module testbench;

    localparam int                          LIST_DEPTH  = olief_pkg::LIST_DEPTH_DEF;
    localparam logic [olief_pkg::REQ_W-1:0] REQ_SPARE   = 2'd3;
    localparam int                          ITEM_TOTAL  = 1600;
    localparam int                          STALL_LIMIT = 1000;
    localparam int                          TAIL_CYCLES = 8;
    localparam int                          IDLE_PCT    = 7;
    localparam logic signed [31:0]          VAL_MIN     = 32'sh80000000;
    localparam logic signed [31:0]          VAL_MAX     = 32'sh7fffffff;
    localparam logic signed [31:0]          VAL_ONES    = 32'shffffffff;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [olief_pkg::REQ_W-1:0]         req_type;
    logic [olief_pkg::POS_W-1:0]         position;
    logic signed [olief_pkg::DATA_W-1:0] value;
    logic                                done;
    logic [olief_pkg::STATUS_W-1:0]      status;
    logic [olief_pkg::FIDX_W-1:0]        found_index;
    logic [olief_pkg::COUNT_W-1:0]       count;
    int                                  fail_count;
    int                                  pending;
    int                                  list_len;
    int                                  n_sent;
    int                                  stall_cycles;
    logic signed [olief_pkg::DATA_W-1:0] recent [8];

    ordered_list_insert_erase_find #(
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .count       (count)
    );

    olief_list_checker #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .count       (count),
        .fail_count  (fail_count),
        .pending     (pending),
        .list_len    (list_len)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // mostly a small set so that finds hit and duplicates occur
    function automatic logic signed [olief_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0:       return 0;
            1:       return VAL_ONES;
            2:       return VAL_MIN;
            3:       return VAL_MAX;
            4, 5, 6: return $urandom_range(1, 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(
        input logic [olief_pkg::REQ_W-1:0]         r,
        input logic [olief_pkg::POS_W-1:0]         p,
        input logic signed [olief_pkg::DATA_W-1:0] v
    );
        bit quiet;
        quiet = (n_sent >= 700 && n_sent < 1000);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        req_type <= r;
        position <= p;
        value    <= v;
        if (r == olief_pkg::REQ_INSERT)
            recent[n_sent % 8] = v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
        n_sent++;
    endtask

    initial
    begin
        int                                  mode;
        int                                  burst;
        int                                  roll;
        int                                  ins_cut;
        int                                  era_cut;
        int                                  len;
        logic [olief_pkg::REQ_W-1:0]         r;
        logic [olief_pkg::POS_W-1:0]         p;
        logic signed [olief_pkg::DATA_W-1:0] v;

        rst_n        = 1'b0;
        start        = 1'b0;
        req_type     = olief_pkg::REQ_INSERT;
        position     = '0;
        value        = '0;
        n_sent       = 0;
        stall_cycles = 0;
        for (int i = 0; i < 8; i++)
            recent[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty list corners
        issue(olief_pkg::REQ_FIND, 0, 0);
        issue(olief_pkg::REQ_ERASE, 0, 0);
        issue(olief_pkg::REQ_INSERT, 1, 5);
        issue(REQ_SPARE, 31, VAL_ONES);

        // fill to capacity with front and back inserts, extremes and a duplicate
        for (int i = 0; i < LIST_DEPTH; i++)
            issue(olief_pkg::REQ_INSERT, (i % 3 == 0) ? 5'd0 : 5'(i),
                  (i == 0) ? VAL_MIN : (i == 1 || i == 5) ? VAL_MAX : $urandom);

        issue(olief_pkg::REQ_INSERT, 0, 7);
        issue(olief_pkg::REQ_FIND, 31, VAL_MAX);
        issue(olief_pkg::REQ_FIND, 0, VAL_MIN);
        issue(olief_pkg::REQ_ERASE, 16, 0);
        issue(olief_pkg::REQ_ERASE, 31, 0);
        issue(olief_pkg::REQ_ERASE, 15, 0);
        issue(olief_pkg::REQ_ERASE, 0, 0);
        issue(REQ_SPARE, 0, 0);

        // bursts that grow, shrink or churn the list
        while (n_sent < ITEM_TOTAL)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(20, 60);
            case (mode)
                0:
                begin
                    ins_cut = 60;
                    era_cut = 75;
                end
                1:
                begin
                    ins_cut = 15;
                    era_cut = 75;
                end
                default:
                begin
                    ins_cut = 40;
                    era_cut = 70;
                end
            endcase
            repeat (burst)
            begin
                len  = list_len;
                roll = $urandom_range(99);
                r = (roll < ins_cut) ? olief_pkg::REQ_INSERT :
                    (roll < era_cut) ? olief_pkg::REQ_ERASE  :
                    (roll < 95)      ? olief_pkg::REQ_FIND   : REQ_SPARE;
                if ($urandom_range(99) < 12)
                    p = $urandom_range(31);
                else
                begin
                    case ($urandom_range(2))
                        0:       p = 0;
                        1:       p = (r == olief_pkg::REQ_ERASE && len > 0) ? len - 1 : len;
                        default: p = (r != olief_pkg::REQ_ERASE) ? $urandom_range(len) :
                                     (len > 0) ? $urandom_range(len - 1) : 0;
                    endcase
                end
                if (r == olief_pkg::REQ_FIND && $urandom_range(2) == 0)
                    v = recent[$urandom_range(7)];
                else
                    v = pick_value();
                issue(r, p, v);
            end
        end

        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/olief_pkg.sv
hw/rtl/olief_cell.sv
hw/rtl/olief_scan.sv
hw/rtl/ordered_list_insert_erase_find.sv
tb/olief_list_checker.sv
tb/testbench.sv
